/* src/cmp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cmp_pkg
// shared types and constants of the hard-iron calibrated compass heading block
// ----------------------------------------------------------------------------
package cmp_pkg;

  localparam int CORDIC_STEPS_DEFAULT = 16;
  localparam int ATAN_LEN             = 24;
  localparam int QUEUE_DEPTH          = 4;
  localparam int QPTR_W               = $clog2(QUEUE_DEPTH);

  localparam int CORR_W   = 18;
  localparam int PRESHIFT = 24;
  // vector width: corrected value, prescale and cordic gain headroom
  localparam int VEC_W    = CORR_W + PRESHIFT + 4;
  localparam int ANG_W    = 27;

  localparam logic [15:0] CALIB_SAMPLES_RESET = 16'd500;

  localparam logic signed [ANG_W-1:0] DEG180       = 27'sd11796480;
  localparam logic signed [ANG_W-1:0] DEG360       = 27'sd23592960;
  localparam logic signed [ANG_W-1:0] ROUND_HALF   = 27'sd256;
  localparam logic        [16:0]      HEADING_FULL = 17'd46080;

  // atan(2^-i) in 2^-16 degree
  localparam logic signed [ANG_W-1:0] ATAN_TAB [ATAN_LEN] = '{
    27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945,
    27'sd234379,  27'sd117304,  27'sd58666,  27'sd29335,
    27'sd14668,   27'sd7334,    27'sd3667,   27'sd1833,
    27'sd917,     27'sd458,     27'sd229,    27'sd115,
    27'sd57,      27'sd29,      27'sd14,     27'sd7,
    27'sd4,       27'sd2,       27'sd1,      27'sd0
  };

  // one classified item on its way from the front to the back end
  typedef struct packed {
    logic                     op;
    logic signed [CORR_W-1:0] cx;
    logic signed [CORR_W-1:0] cy;
    logic signed [CORR_W-1:0] cz;
    logic                     done;
    logic [15:0]              progress;
  } cmp_job_t;

endpackage
`default_nettype wire

/* src/cmp_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cmp_front
// accepts samples, tracks calibration extremes, applies hard-iron offsets
// ----------------------------------------------------------------------------
module cmp_front (
  input  wire              clk,
  input  wire              rst,
  input  wire              cfg_we,
  input  wire [15:0]       cfg_wdata,
  input  wire              accept,
  input  wire              op,
  input  wire [47:0]       sample,
  output cmp_pkg::cmp_job_t job
);
  import cmp_pkg::*;

  logic [15:0] calib_samples;
  logic signed [15:0] max_x, min_x, max_y, min_y, max_z, min_z;
  logic [15:0] sample_count;
  logic signed [16:0] offset_sum_x, offset_sum_y, offset_sum_z;

  logic signed [15:0] rx, ry, rz;
  logic signed [15:0] bmax_x, bmin_x, bmax_y, bmin_y, bmax_z, bmin_z;
  logic signed [15:0] nmax_x, nmin_x, nmax_y, nmin_y, nmax_z, nmin_z;
  logic [15:0] target, count_inc;
  logic        done;

  function automatic logic signed [15:0] smax(logic signed [15:0] a, logic signed [15:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic signed [15:0] smin(logic signed [15:0] a, logic signed [15:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [CORR_W-1:0] correct(logic signed [15:0] raw,
                                                       logic signed [16:0] off);
    return {raw[15], raw, 1'b0} - {off[16], off};
  endfunction

  function automatic logic signed [16:0] pair_sum(logic signed [15:0] a, logic signed [15:0] b);
    return {a[15], a} + {b[15], b};
  endfunction

  // bytes arrive high first
  assign rx = {sample[7:0],   sample[15:8]};
  assign rz = {sample[23:16], sample[31:24]};
  assign ry = {sample[39:32], sample[47:40]};

  // first item of a run starts from zero extremes
  assign bmax_x = (sample_count == 16'd0) ? 16'sd0 : max_x;
  assign bmin_x = (sample_count == 16'd0) ? 16'sd0 : min_x;
  assign bmax_y = (sample_count == 16'd0) ? 16'sd0 : max_y;
  assign bmin_y = (sample_count == 16'd0) ? 16'sd0 : min_y;
  assign bmax_z = (sample_count == 16'd0) ? 16'sd0 : max_z;
  assign bmin_z = (sample_count == 16'd0) ? 16'sd0 : min_z;

  assign nmax_x = smax(bmax_x, rx);
  assign nmin_x = smin(bmin_x, rx);
  assign nmax_y = smax(bmax_y, ry);
  assign nmin_y = smin(bmin_y, ry);
  assign nmax_z = smax(bmax_z, rz);
  assign nmin_z = smin(bmin_z, rz);

  assign target    = (calib_samples == 16'd0) ? 16'd1 : calib_samples;
  assign count_inc = sample_count + 16'd1;
  assign done      = (count_inc >= target);

  always_comb begin
    job.op = op;
    if (op) begin
      job.cx       = correct(rx, offset_sum_x);
      job.cy       = correct(ry, offset_sum_y);
      job.cz       = correct(rz, offset_sum_z);
      job.done     = 1'b0;
      job.progress = sample_count;
    end else begin
      job.cx       = '0;
      job.cy       = '0;
      job.cz       = '0;
      job.done     = done;
      job.progress = count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      calib_samples <= CALIB_SAMPLES_RESET;
    end else if (cfg_we) begin
      calib_samples <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_x        <= '0;
      min_x        <= '0;
      max_y        <= '0;
      min_y        <= '0;
      max_z        <= '0;
      min_z        <= '0;
      sample_count <= '0;
      offset_sum_x <= '0;
      offset_sum_y <= '0;
      offset_sum_z <= '0;
    end else if (accept && !op) begin
      max_x <= nmax_x;
      min_x <= nmin_x;
      max_y <= nmax_y;
      min_y <= nmin_y;
      max_z <= nmax_z;
      min_z <= nmin_z;
      if (done) begin
        sample_count <= '0;
        offset_sum_x <= pair_sum(nmax_x, nmin_x);
        offset_sum_y <= pair_sum(nmax_y, nmin_y);
        offset_sum_z <= pair_sum(nmax_z, nmin_z);
      end else begin
        sample_count <= count_inc;
      end
    end
  end

endmodule
`default_nettype wire

/* src/cmp_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cmp_queue
// short job queue between front and back end
// ----------------------------------------------------------------------------
module cmp_queue (
  input  wire               clk,
  input  wire               rst,
  input  wire               push,
  input  cmp_pkg::cmp_job_t push_job,
  output logic              full,
  input  wire               pop,
  output cmp_pkg::cmp_job_t head_job,
  output logic              not_empty
);
  import cmp_pkg::*;

  cmp_job_t         slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full      = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head_job  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

/* src/cmp_cordic.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cmp_cordic
// pipelined vectoring cordic, one rotation per stage, with output register
// ----------------------------------------------------------------------------
module cmp_cordic #(
  parameter int CORDIC_STEPS = cmp_pkg::CORDIC_STEPS_DEFAULT
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  input  cmp_pkg::cmp_job_t in_job,
  output logic              in_pop,
  output logic              out_valid,
  input  wire               out_ready,
  output logic [87:0]       out_data,
  output logic              out_last
);
  import cmp_pkg::*;

  localparam int NSTEP = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

  logic                    advance;
  logic                    v_s   [NSTEP+1];
  logic signed [VEC_W-1:0] x_s   [NSTEP+1];
  logic signed [VEC_W-1:0] y_s   [NSTEP+1];
  logic signed [ANG_W-1:0] z_s   [NSTEP+1];
  logic                    zero_s[NSTEP+1];
  cmp_job_t                job_s [NSTEP+1];

  logic signed [VEC_W-1:0] x_pre, y_pre;
  logic signed [ANG_W-1:0] z_wrap, z_round;
  logic [16:0]             z_q;
  logic [15:0]             heading;

  assign advance = !out_valid || out_ready;
  assign in_pop  = advance && in_valid;

  assign x_pre = {{(VEC_W-CORR_W-PRESHIFT){in_job.cx[CORR_W-1]}}, in_job.cx, PRESHIFT'(0)};
  assign y_pre = {{(VEC_W-CORR_W-PRESHIFT){in_job.cy[CORR_W-1]}}, in_job.cy, PRESHIFT'(0)};

  // entry stage: fold the left half plane over with 180 degrees
  always_ff @(posedge clk) begin
    if (advance) begin
      job_s[0]  <= in_job;
      zero_s[0] <= (in_job.cx == '0) && (in_job.cy == '0);
      if (in_job.cx < 0) begin
        x_s[0] <= -x_pre;
        y_s[0] <= -y_pre;
        z_s[0] <= DEG180;
      end else begin
        x_s[0] <= x_pre;
        y_s[0] <= y_pre;
        z_s[0] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s[0] <= 1'b0;
    end else if (advance) begin
      v_s[0] <= in_valid;
    end
  end

  for (genvar g = 0; g < NSTEP; g++) begin : g_stage
    logic signed [VEC_W-1:0] xs, ys;

    assign xs = x_s[g] >>> g;
    assign ys = y_s[g] >>> g;

    always_ff @(posedge clk) begin
      if (advance) begin
        job_s[g+1]  <= job_s[g];
        zero_s[g+1] <= zero_s[g];
        if (!y_s[g][VEC_W-1]) begin
          x_s[g+1] <= x_s[g] + ys;
          y_s[g+1] <= y_s[g] - xs;
          z_s[g+1] <= z_s[g] + ATAN_TAB[g];
        end else begin
          x_s[g+1] <= x_s[g] - ys;
          y_s[g+1] <= y_s[g] + xs;
          z_s[g+1] <= z_s[g] - ATAN_TAB[g];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[g+1] <= 1'b0;
      end else if (advance) begin
        v_s[g+1] <= v_s[g];
      end
    end
  end

  // wrap into a full circle, round half up to 1/128 degree
  assign z_wrap  = (z_s[NSTEP] < 0) ? (z_s[NSTEP] + DEG360) : z_s[NSTEP];
  assign z_round = z_wrap + ROUND_HALF;
  assign z_q     = z_round[25:9];
  assign heading = zero_s[NSTEP] ? 16'd0 :
                   (z_q >= HEADING_FULL) ? 16'(z_q - HEADING_FULL) : z_q[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= v_s[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= {2'b00, job_s[NSTEP].progress, job_s[NSTEP].cz,
                   job_s[NSTEP].cy, job_s[NSTEP].cx, heading};
      out_last <= job_s[NSTEP].done;
    end
  end

endmodule
`default_nettype wire

/* src/compass_heading_hard_iron_cal.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// compass_heading_hard_iron_cal
// hard-iron calibrated magnetometer heading with pipelined cordic atan2
// ----------------------------------------------------------------------------
//
// channel   direction  tdata                                   side band
// s_*       in         x_hi x_lo z_hi z_lo y_hi y_lo (48 bit)  tuser = op
// m_*       out        heading corr_x corr_y corr_z progress   tlast = calib_done
// cfg_*     in         calib_samples (16 bit, write only)      -
//
// one transfer per cycle is sustained in both directions while m_tready
// stays high; the back end is a cordic pipeline of one rotation per stage:
// a sample is written into the queue, popped into the entry stage (which
// also loads the half-plane fold), taken through the rotation stages in
// turn and then into the output register; CORDIC_STEPS above 24 counts as 24.
// calibration state is updated at the input transfer itself, so a heading
// sample right behind the sample that ends a run already sees the new offsets.
// reset (synchronous) clears the extremes, run count and offsets, empties the
// queue and pipeline, and sets calib_samples to 500.
// m_tready low while a result is held freezes the pipeline; the front keeps
// taking samples until the four-entry queue is full.
// ----------------------------------------------------------------------------
module compass_heading_hard_iron_cal #(
  parameter int CORDIC_STEPS = cmp_pkg::CORDIC_STEPS_DEFAULT
) (
  input  wire         clk,
  input  wire         rst,
  // configuration: calib_samples
  input  wire         cfg_we,
  input  wire  [15:0] cfg_wdata,
  // samples in
  input  wire         s_tvalid,
  output logic        s_tready,
  // tdata from bit 0: x_hi, x_lo, z_hi, z_lo, y_hi, y_lo
  input  wire  [47:0] s_tdata,
  // tuser: op (0 = calibration, 1 = heading)
  input  wire         s_tuser,
  // results out
  output logic        m_tvalid,
  input  wire         m_tready,
  // tdata from bit 0: heading[16], corr_x[18], corr_y[18], corr_z[18],
  // calib_progress[16], two zero pad bits
  output logic [87:0] m_tdata,
  // tlast: calib_done
  output logic        m_tlast
);
  import cmp_pkg::*;

  cmp_job_t front_job;
  cmp_job_t head_job;
  logic     queue_full;
  logic     queue_not_empty;
  logic     queue_pop;
  logic     accept;

  // the front never stalls on its own; only a full queue holds it off
  assign s_tready = !queue_full;
  assign accept   = s_tvalid && s_tready;

  cmp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .op        (s_tuser),
    .sample    (s_tdata),
    .job       (front_job)
  );

  cmp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_job  (front_job),
    .full      (queue_full),
    .pop       (queue_pop),
    .head_job  (head_job),
    .not_empty (queue_not_empty)
  );

  cmp_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (queue_not_empty),
    .in_job    (head_job),
    .in_pop    (queue_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule
`default_nettype wire

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the hard-iron calibrated compass heading block:
// samples go in from a queue through a stream driver, mostly with random gaps, every
// accepted sample is run through a local calibration and cordic predictor,
// and each result transfer is compared field by field with the oldest
// prediction; calib_samples is rewritten between phases while the block idles
// ----------------------------------------------------------------------------
module tb;

  localparam int STEPS  = cmp_pkg::CORDIC_STEPS_DEFAULT;
  // pipeline depth plus queue, with margin
  localparam int SETTLE = STEPS + 24;
  localparam int LIMIT  = 200000;

  localparam logic OP_CALIB   = 1'b0;
  localparam logic OP_HEADING = 1'b1;

  // angles in 2^-16 degree, FULL_TURN in 1/128 degree
  localparam longint ANG_180   = 64'sd11796480;
  localparam longint ANG_360   = 64'sd23592960;
  localparam longint FULL_TURN = 64'sd46080;
  localparam longint ATAN_STEP [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef struct packed {
    logic        op;
    logic [47:0] data;
  } sample_t;

  typedef struct packed {
    logic [15:0]        heading;
    logic signed [17:0] corr_x;
    logic signed [17:0] corr_y;
    logic signed [17:0] corr_z;
    logic               done;
    logic [15:0]        progress;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = 16'd0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = 48'd0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [87:0] m_tdata;
  logic        m_tlast;

  // tdata from bit 0: x_hi x_lo z_hi z_lo y_hi y_lo; tuser: op
  // m_tdata from bit 0: heading corr_x corr_y corr_z calib_progress; tlast: calib_done
  compass_heading_hard_iron_cal #(
    .CORDIC_STEPS(STEPS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // predictor copy of the block state
  logic [15:0]        calib_len = 16'd500;
  logic signed [15:0] hi_x = '0, lo_x = '0, hi_y = '0, lo_y = '0, hi_z = '0, lo_z = '0;
  logic [15:0]        run_len = '0;
  logic signed [16:0] sum_x = '0, sum_y = '0, sum_z = '0;

  sample_t samples_to_send [$];
  result_t due_results [$];
  sample_t next_sample;
  result_t want_r;

  int  n_queued = 0;
  int  n_accepted = 0;
  int  results_checked = 0;
  int  cal_seen = 0;
  int  head_seen = 0;
  int  runs_ended = 0;
  int  cfg_writes = 0;
  int  fails = 0;
  int  cycle_count = 0;
  bit  gaps_on = 1'b1;
  bit  in_taken = 1'b0;

  // cordic atan2 of the corrected vector, 1/128 degree, wrapped to 0..46079
  function automatic logic [15:0] heading_of_vector(input int cx, input int cy);
    longint vx, vy, ang, xs, ys, hd;
    int     n;
    if (cx == 0 && cy == 0) return 16'd0;
    vx  = longint'(cx) * 64'sd16777216;
    vy  = longint'(cy) * 64'sd16777216;
    ang = 0;
    // left half plane: rotate by 180 degrees first
    if (vx < 0) begin
      vx  = -vx;
      vy  = -vy;
      ang = ANG_180;
    end
    n = (STEPS < 24) ? STEPS : 24;
    for (int i = 0; i < n; i++) begin
      xs = vx >>> i;
      ys = vy >>> i;
      if (vy >= 0) begin
        vx  = vx + ys;
        vy  = vy - xs;
        ang = ang + ATAN_STEP[i];
      end else begin
        vx  = vx - ys;
        vy  = vy + xs;
        ang = ang - ATAN_STEP[i];
      end
    end
    if (ang < 0) ang = ang + ANG_360;
    hd = (ang + 256) >>> 9;
    // a heading that rounds up to the full circle reads as zero
    if (hd >= FULL_TURN) hd = hd - FULL_TURN;
    return hd[15:0];
  endfunction

  // result caused by one accepted sample; updates the calibration copy
  function automatic result_t heading_result_for(input sample_t s);
    result_t            r;
    logic signed [15:0] rx, ry, rz;
    int                 target, cx, cy, cz;
    rx = {s.data[7:0], s.data[15:8]};
    rz = {s.data[23:16], s.data[31:24]};
    ry = {s.data[39:32], s.data[47:40]};
    r  = '0;
    if (s.op == OP_CALIB) begin
      cal_seen++;
      target = (calib_len == 16'd0) ? 1 : int'(calib_len);
      if (run_len == 16'd0) begin
        hi_x = '0; lo_x = '0; hi_y = '0; lo_y = '0; hi_z = '0; lo_z = '0;
      end
      if (rx > hi_x) hi_x = rx;
      if (rx < lo_x) lo_x = rx;
      if (rz > hi_z) hi_z = rz;
      if (rz < lo_z) lo_z = rz;
      if (ry > hi_y) hi_y = ry;
      if (ry < lo_y) lo_y = ry;
      run_len    = run_len + 16'd1;
      r.done     = (int'(run_len) >= target);
      r.progress = run_len;
      if (r.done) begin
        sum_x   = {hi_x[15], hi_x} + {lo_x[15], lo_x};
        sum_y   = {hi_y[15], hi_y} + {lo_y[15], lo_y};
        sum_z   = {hi_z[15], hi_z} + {lo_z[15], lo_z};
        run_len = '0;
        runs_ended++;
      end
    end else begin
      head_seen++;
      cx = 2 * int'(rx) - int'(sum_x);
      cy = 2 * int'(ry) - int'(sum_y);
      cz = 2 * int'(rz) - int'(sum_z);
      r.heading  = heading_of_vector(cx, cy);
      r.corr_x   = cx[17:0];
      r.corr_y   = cy[17:0];
      r.corr_z   = cz[17:0];
      r.progress = run_len;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      fails++;
    end
  endtask

  // input driver and result back-pressure, both changed at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      if (!s_tvalid || in_taken) begin
        if (samples_to_send.size() != 0 && !(gaps_on && $urandom_range(0, 99) < 34)) begin
          next_sample = samples_to_send.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= next_sample.data;
          s_tuser  <= next_sample.op;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= !(gaps_on && $urandom_range(0, 99) < 34);
    end
  end

  // monitor: predict on each input transfer, check each output transfer
  always @(posedge clk) begin
    in_taken <= !rst && s_tvalid && s_tready;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        due_results.push_back(heading_result_for('{op: s_tuser, data: s_tdata}));
        n_accepted++;
      end
      if (m_tvalid && m_tready) begin
        if (due_results.size() == 0) begin
          $error("result transfer with no sample waiting: tdata %h", m_tdata);
          fails++;
        end else begin
          want_r = due_results.pop_front();
          check_field("heading", int'(want_r.heading), int'(m_tdata[15:0]));
          check_field("corr_x", int'($signed(want_r.corr_x)), int'($signed(m_tdata[33:16])));
          check_field("corr_y", int'($signed(want_r.corr_y)), int'($signed(m_tdata[51:34])));
          check_field("corr_z", int'($signed(want_r.corr_z)), int'($signed(m_tdata[69:52])));
          check_field("calib_progress", int'(want_r.progress), int'(m_tdata[85:70]));
          check_field("calib_done", int'(want_r.done), int'(m_tlast));
          results_checked++;
        end
      end
    end
  end

  // guard against a hang
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", LIMIT, due_results.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic queue_sample(input logic op, input logic [15:0] x, input logic [15:0] y,
                              input logic [15:0] z);
    // big-endian words, high byte in the lower tdata byte
    samples_to_send.push_back('{op: op,
                                data: {y[7:0], y[15:8], z[7:0], z[15:8], x[7:0], x[15:8]}});
    n_queued++;
  endtask

  // every queued sample accepted and answered, then let the pipeline drain
  task automatic wait_block_idle();
    while (!(n_accepted == n_queued && due_results.size() == 0)) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_calib_len(input logic [15:0] v);
    wait_block_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    calib_len = v;
    cfg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // axis word: extremes, a cluster round a centre, or anything at all
  function automatic logic [15:0] axis_word(input int centre, input int spread);
    int v;
    case ($urandom_range(0, 9))
      0:          v = 32767;
      1:          v = -32768;
      2, 3, 4, 5: v = centre + int'($urandom_range(0, 2 * spread)) - spread;
      default:    v = int'($urandom & 32'hFFFF);
    endcase
    return v[15:0];
  endfunction

  initial begin
    int len, n_head, spread, bx, by, bz, phase, random_items, pick;
    phase        = 0;
    random_items = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: no offsets yet, calib_samples at its reset value
    queue_sample(OP_HEADING, 16'sd0, 16'sd0, 16'sd0);         // zero vector
    queue_sample(OP_HEADING, 16'sd32767, 16'sd0, 16'sd0);
    queue_sample(OP_HEADING, -16'sd32768, 16'sd0, 16'sd0);    // left half plane
    queue_sample(OP_HEADING, 16'sd0, 16'sd32767, 16'sd0);
    queue_sample(OP_HEADING, 16'sd0, -16'sd32768, 16'sd0);    // negative total wraps
    queue_sample(OP_HEADING, -16'sd32768, -16'sd32768, 16'sd32767);
    queue_sample(OP_HEADING, 16'sd32767, -16'sd1, 16'sd0);    // rounds up to full circle
    queue_sample(OP_HEADING, -16'sd1, 16'sd1, -16'sd32768);
    queue_sample(OP_CALIB, 16'sd1000, -16'sd2000, 16'sd500);
    queue_sample(OP_CALIB, -16'sd3000, 16'sd4000, -16'sd7000);
    queue_sample(OP_HEADING, 16'sd100, 16'sd100, 16'sd100);   // heading within a run
    set_calib_len(16'hFFFF);
    queue_sample(OP_CALIB, 16'sd32767, 16'sd32767, 16'sd32767);
    queue_sample(OP_CALIB, -16'sd32768, -16'sd32768, -16'sd32768);
    // register lowered below the count already taken
    set_calib_len(16'd3);
    queue_sample(OP_CALIB, 16'sd5, -16'sd5, 16'sd7);
    queue_sample(OP_HEADING, 16'sd0, 16'sd0, 16'sd0);
    queue_sample(OP_HEADING, 16'sd32767, -16'sd32768, 16'sd1);
    // zero acts as one: every calibration sample ends a run
    set_calib_len(16'd0);
    queue_sample(OP_CALIB, 16'sd32767, 16'sd32767, -16'sd32768);
    queue_sample(OP_HEADING, -16'sd32768, -16'sd32768, 16'sd32767);
    queue_sample(OP_CALIB, -16'sd32768, -16'sd32768, 16'sd32767);
    queue_sample(OP_HEADING, 16'sd32767, 16'sd32767, -16'sd32768);
    set_calib_len(16'd1);
    queue_sample(OP_CALIB, 16'sd2, 16'sd4, -16'sd6);
    queue_sample(OP_HEADING, 16'sd1, 16'sd2, 16'sd3);

    // random phases: a full calibration run, then a burst of headings
    while (random_items < 850) begin
      gaps_on = !(phase == 2 || phase == 3);
      pick    = $urandom_range(0, 9);
      if (pick == 0)      len = 0;
      else if (pick == 1) len = $urandom_range(20, 40);
      else                len = $urandom_range(1, 12);
      set_calib_len(len[15:0]);
      bx     = int'($urandom_range(0, 16000)) - 8000;
      by     = int'($urandom_range(0, 16000)) - 8000;
      bz     = int'($urandom_range(0, 16000)) - 8000;
      spread = $urandom_range(1, 3000);
      for (int i = 0; i < ((len == 0) ? 1 : len); i++) begin
        // now and then a heading sample inside the run
        if ($urandom_range(0, 9) == 0) begin
          queue_sample(OP_HEADING, axis_word(bx, spread), axis_word(by, spread),
                       axis_word(bz, spread));
          random_items++;
        end
        queue_sample(OP_CALIB, axis_word(bx, spread), axis_word(by, spread),
                     axis_word(bz, spread));
        random_items++;
      end
      // offsets settled before headings are aimed at them
      wait_block_idle();
      n_head = $urandom_range(20, 50);
      for (int i = 0; i < n_head; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          // stray calibration sample, starts or extends a broken run
          queue_sample(OP_CALIB, axis_word(bx, spread), axis_word(by, spread),
                       axis_word(bz, spread));
        end else if (pick < 14) begin
          // raw right on the offset: corrected vector at or next to zero
          queue_sample(OP_HEADING, 16'(int'(sum_x) >>> 1), 16'(int'(sum_y) >>> 1),
                       16'(int'(sum_z) >>> 1));
        end else begin
          queue_sample(OP_HEADING, axis_word(int'(sum_x) >>> 1, 2000),
                       axis_word(int'(sum_y) >>> 1, 2000), axis_word(int'(sum_z) >>> 1, 2000));
        end
        random_items++;
      end
      phase++;
    end
    gaps_on = 1'b1;

    wait_block_idle();
    $display("%0d samples in (%0d calibration, %0d heading), %0d results checked",
             n_accepted, cal_seen, head_seen, results_checked);
    $display("%0d calibration runs completed over %0d register writes, %0d phases",
             runs_ended, cfg_writes, phase);
    if (fails == 0 && due_results.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
